@@ hw/rtl/spb_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the broad phase.
package spb_pkg;

    localparam int MAX_BODIES_DEF = 32;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_UNUSED = 2'd2;

    typedef enum logic [1:0] {
        DEC_DONE,
        DEC_ADD,
        DEC_REMOVE,
        DEC_UPDATE
    } t_dec;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECODE   = 13'b0000000000010,
        S_ADD0     = 13'b0000000000100,
        S_ADD1     = 13'b0000000001000,
        S_MV_START = 13'b0000000010000,
        S_MV_LOAD  = 13'b0000000100000,
        S_MV_CMP   = 13'b0000001000000,
        S_MV_END   = 13'b0000010000000,
        S_CLR      = 13'b0000100000000,
        S_RM_RD    = 13'b0001000000000,
        S_RM_WR    = 13'b0010000000000,
        S_EMIT     = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic idle;
        logic decode;
        logic add0;
        logic add1;
        logic mv_start;
        logic mv_load;
        logic mv_cmp;
        logic mv_end;
        logic clr;
        logic rm_rd;
        logic rm_wr;
        logic emit;
        logic done_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        t_dec dec;
        logic walk_go;
        logic mv_last;
        logic rm_more;
        logic rm_axis1;
        logic emit_adv;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/spb_req_if.sv @@
// Request channel: one box command per handshake.
interface spb_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [4:0]         body_id;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;

    modport source (output valid, cmd, body_id, min_x, min_y, max_x, max_y, input ready);
    modport sink   (input valid, cmd, body_id, min_x, min_y, max_x, max_y, output ready);
endinterface

@@ hw/rtl/spb_res_if.sv @@
// Result channel: pair changes and the command-done item.
interface spb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] body_a;
    logic [4:0] body_b;
    logic [1:0] status;
    logic       last;

    modport source (output valid, kind, body_a, body_b, status, last, input ready);
    modport sink   (input valid, kind, body_a, body_b, status, last, output ready);
endinterface

@@ hw/rtl/spb_ctrl.sv @@
// Command sequencer: walks each request through decode, endpoint moves and emission.
module spb_ctrl import spb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_st,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_st.in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_st.dec)
                    DEC_DONE:   n_state = S_DONE;
                    DEC_ADD:    n_state = S_ADD0;
                    DEC_REMOVE: n_state = S_CLR;
                    DEC_UPDATE: n_state = S_MV_START;
                endcase
            end
            S_ADD0:     n_state = S_ADD1;
            S_ADD1:     n_state = S_MV_START;
            S_MV_START: n_state = S_MV_LOAD;
            S_MV_LOAD:  n_state = i_st.walk_go ? S_MV_CMP : S_MV_END;
            S_MV_CMP:   n_state = i_st.walk_go ? S_MV_CMP : S_MV_END;
            S_MV_END:   n_state = i_st.mv_last ? S_EMIT : S_MV_START;
            S_CLR:      n_state = S_RM_RD;
            S_RM_RD: begin
                if (i_st.rm_more)       n_state = S_RM_WR;
                else if (i_st.rm_axis1) n_state = S_EMIT;
            end
            S_RM_WR:    n_state = S_RM_RD;
            S_EMIT: begin
                if (i_st.emit_adv && i_st.emit_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.idle     = (r_state == S_IDLE);
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.add0     = (r_state == S_ADD0);
        o_cmd.add1     = (r_state == S_ADD1);
        o_cmd.mv_start = (r_state == S_MV_START);
        o_cmd.mv_load  = (r_state == S_MV_LOAD);
        o_cmd.mv_cmp   = (r_state == S_MV_CMP);
        o_cmd.mv_end   = (r_state == S_MV_END);
        o_cmd.clr      = (r_state == S_CLR);
        o_cmd.rm_rd    = (r_state == S_RM_RD);
        o_cmd.rm_wr    = (r_state == S_RM_WR);
        o_cmd.emit     = (r_state == S_EMIT);
        o_cmd.done_ld  = (r_state == S_DONE);
    end

endmodule

@@ hw/rtl/spb_dp.sv @@
// Datapath: endpoint list memories, box table, positions, pair matrix and result register.
module spb_dp import spb_pkg::*; #(
    parameter int MAX_BODIES = MAX_BODIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_st,
    spb_req_if.sink   i_req,
    spb_res_if.source o_res
);

    localparam int IDW = $clog2(MAX_BODIES);
    localparam int EPN = 2 * MAX_BODIES;
    localparam int EPW = $clog2(EPN);
    localparam int CNW = EPW + 1;
    localparam int EW  = COORD_BITS + 1 + IDW;
    localparam logic [IDW-1:0] LAST_ID  = IDW'(MAX_BODIES - 1);
    localparam logic [CNW:0]   EP_LIMIT = (CNW + 1)'(EPN);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // request registers
    logic [1:0]      r_op;
    logic [4:0]      r_id5;
    t_coord          r_lo [2];
    t_coord          r_hi [2];

    // command context
    logic [IDW-1:0]        r_tgt;
    logic [MAX_BODIES-1:0] r_before;
    logic [4:0]            r_dn_a;
    logic [1:0]            r_dn_st;
    logic                  r_is_add;
    logic [1:0]            r_mv;
    logic                  r_left;
    logic [EPW-1:0]        r_i;
    logic [CNW-1:0]        r_r, r_w;
    logic                  r_ax;
    logic [IDW-1:0]        r_o;

    // persistent state
    logic [CNW-1:0]        r_cnt;
    logic [MAX_BODIES-1:0] r_slot;
    logic [MAX_BODIES-1:0] r_pair [MAX_BODIES];
    t_coord                r_blo  [MAX_BODIES][2];
    t_coord                r_bhi  [MAX_BODIES][2];
    logic [EPW-1:0]        r_pos  [MAX_BODIES][4];
    logic [EW-1:0]         r_mem_x [EPN];
    logic [EW-1:0]         r_mem_y [EPN];
    logic [EW-1:0]         r_rd_x, r_rd_y;

    // result register
    logic       r_ov;
    logic [1:0] r_okind;
    logic [4:0] r_oa, r_ob;
    logic [1:0] r_ost;
    logic       r_olast;

    logic                  accept;
    logic                  free_found;
    logic [IDW-1:0]        free_id;
    logic [IDW-1:0]        id_w;
    logic                  id_ok;
    logic                  add_fail;
    t_dec                  dec;
    logic [4:0]            dn_a;
    logic [1:0]            dn_st;
    logic [IDW-1:0]        tgt_dec;
    logic                  cur_ax;
    t_coord                nv;
    logic [EW-1:0]         rd;
    t_coord                rd_val;
    logic                  rd_min;
    logic [IDW-1:0]        rd_id;
    logic                  me_min;
    logic                  left_ld;
    logic                  ok_i, ok_j;
    logic [EPW-1:0]        j;
    logic                  swap;
    logic                  walk_go;
    logic                  do_set, do_clr, ovl, other;
    logic                  keep;
    logic [EPW-1:0]        raddr, waddr;
    logic                  we_x, we_y;
    logic [EW-1:0]         wd_x, wd_y;
    logic                  rm_more;
    logic                  diff;
    logic                  out_free;
    logic                  pair_ld;

    assign accept = i_cmd.idle && i_req.valid;
    assign i_req.ready = i_cmd.idle;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_id    = '0;
        for (int s = MAX_BODIES - 1; s >= 0; s--) begin
            if (!r_slot[s]) begin
                free_found = 1'b1;
                free_id    = IDW'(s);
            end
        end
    end

    assign id_w     = IDW'(r_id5);
    assign id_ok    = (int'(r_id5) < MAX_BODIES) && r_slot[id_w];
    assign add_fail = !free_found || (({1'b0, r_cnt} + (CNW + 1)'(2)) > EP_LIMIT);

    always_comb begin
        unique case (r_op)
            CMD_ADD: begin
                dec   = add_fail ? DEC_DONE : DEC_ADD;
                dn_a  = add_fail ? 5'd0 : 5'(free_id);
                dn_st = add_fail ? STAT_FULL : STAT_OK;
            end
            CMD_REMOVE: begin
                dec   = id_ok ? DEC_REMOVE : DEC_DONE;
                dn_a  = r_id5;
                dn_st = id_ok ? STAT_OK : STAT_UNUSED;
            end
            CMD_UPDATE: begin
                dec   = id_ok ? DEC_UPDATE : DEC_DONE;
                dn_a  = r_id5;
                dn_st = id_ok ? STAT_OK : STAT_UNUSED;
            end
            CMD_NONE: begin
                dec   = DEC_DONE;
                dn_a  = 5'd0;
                dn_st = STAT_OK;
            end
        endcase
    end

    assign tgt_dec = (r_op == CMD_ADD) ? free_id : id_w;

    // endpoint walk
    assign cur_ax = (r_op == CMD_REMOVE) ? r_ax : r_mv[1];
    assign nv     = r_mv[0] ? r_hi[r_mv[1]] : r_lo[r_mv[1]];
    assign rd     = cur_ax ? r_rd_y : r_rd_x;
    assign rd_val = t_coord'(rd[EW-1 -: COORD_BITS]);
    assign rd_min = rd[IDW];
    assign rd_id  = rd[IDW-1:0];
    assign me_min = !r_mv[0];

    // the add path always sorts new endpoints toward the low end
    assign left_ld = r_is_add || (nv < rd_val);
    assign ok_i    = left_ld ? (r_i != '0) : ((CNW'(r_i) + CNW'(1)) < r_cnt);
    assign j       = r_left ? (r_i - EPW'(1)) : (r_i + EPW'(1));
    assign swap    = r_left ? (rd_val > nv) : (rd_val < nv);
    assign ok_j    = r_left ? (j != '0) : ((CNW'(j) + CNW'(1)) < r_cnt);
    assign walk_go = i_cmd.mv_load ? ok_i : (swap && ok_j);

    assign other  = (rd_id != r_tgt);
    assign do_set = r_left ? (me_min && !rd_min) : (!me_min && rd_min);
    assign do_clr = r_left ? (!me_min && rd_min) : (me_min && !rd_min);
    assign ovl    = !(r_lo[0] > r_bhi[rd_id][0]) && !(r_blo[rd_id][0] > r_hi[0]) &&
                    !(r_lo[1] > r_bhi[rd_id][1]) && !(r_blo[rd_id][1] > r_hi[1]);

    assign keep    = (rd_id != r_tgt);
    assign rm_more = (r_r < r_cnt);

    always_comb begin
        priority if (i_cmd.mv_start) raddr = r_pos[r_tgt][r_mv];
        else if (i_cmd.mv_load)      raddr = left_ld ? (r_i - EPW'(1)) : (r_i + EPW'(1));
        else if (i_cmd.mv_cmp)       raddr = r_left ? (j - EPW'(1)) : (j + EPW'(1));
        else if (i_cmd.rm_rd)        raddr = r_r[EPW-1:0];
        else                         raddr = '0;
    end

    always_comb begin
        we_x  = 1'b0;
        we_y  = 1'b0;
        waddr = r_i;
        wd_x  = rd;
        wd_y  = rd;
        priority if (i_cmd.add0) begin
            we_x  = 1'b1;
            we_y  = 1'b1;
            waddr = r_cnt[EPW-1:0];
            wd_x  = {r_lo[0], 1'b1, r_tgt};
            wd_y  = {r_lo[1], 1'b1, r_tgt};
        end else if (i_cmd.add1) begin
            we_x  = 1'b1;
            we_y  = 1'b1;
            waddr = r_cnt[EPW-1:0] + EPW'(1);
            wd_x  = {r_hi[0], 1'b0, r_tgt};
            wd_y  = {r_hi[1], 1'b0, r_tgt};
        end else if (i_cmd.mv_cmp && swap) begin
            we_x = !cur_ax;
            we_y = cur_ax;
        end else if (i_cmd.mv_end) begin
            we_x = !cur_ax;
            we_y = cur_ax;
            wd_x = {nv, me_min, r_tgt};
            wd_y = {nv, me_min, r_tgt};
        end else if (i_cmd.rm_wr && keep) begin
            we_x  = !cur_ax;
            we_y  = cur_ax;
            waddr = r_w[EPW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_x) r_mem_x[waddr] <= wd_x;
        if (we_y) r_mem_y[waddr] <= wd_y;
        r_rd_x <= r_mem_x[raddr];
        r_rd_y <= r_mem_y[raddr];
    end

    // endpoint index of each body end
    always_ff @(posedge i_clk) begin
        if (i_cmd.add0) begin
            r_pos[r_tgt][0] <= r_cnt[EPW-1:0];
            r_pos[r_tgt][1] <= r_cnt[EPW-1:0] + EPW'(1);
            r_pos[r_tgt][2] <= r_cnt[EPW-1:0];
            r_pos[r_tgt][3] <= r_cnt[EPW-1:0] + EPW'(1);
        end else if (i_cmd.mv_cmp && swap) begin
            r_pos[rd_id][{cur_ax, !rd_min}] <= r_i;
        end else if (i_cmd.mv_end) begin
            r_pos[r_tgt][r_mv] <= r_i;
        end else if (i_cmd.rm_wr && keep) begin
            r_pos[rd_id][{r_ax, !rd_min}] <= r_w[EPW-1:0];
        end
    end

    // stored boxes
    always_ff @(posedge i_clk) begin
        if (i_cmd.add0 || (i_cmd.decode && dec == DEC_UPDATE)) begin
            r_blo[i_cmd.add0 ? r_tgt : tgt_dec][0] <= r_lo[0];
            r_blo[i_cmd.add0 ? r_tgt : tgt_dec][1] <= r_lo[1];
            r_bhi[i_cmd.add0 ? r_tgt : tgt_dec][0] <= r_hi[0];
            r_bhi[i_cmd.add0 ? r_tgt : tgt_dec][1] <= r_hi[1];
        end
    end

    // pair matrix, slot map and endpoint count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BODIES; k++) r_pair[k] <= '0;
            r_slot <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.add1) begin
                r_pair[r_tgt] <= '0;
                r_slot[r_tgt] <= 1'b1;
                r_cnt         <= r_cnt + CNW'(2);
            end
            if (i_cmd.mv_cmp && swap && other) begin
                if (do_set && ovl) begin
                    r_pair[r_tgt][rd_id] <= 1'b1;
                    r_pair[rd_id][r_tgt] <= 1'b1;
                end
                if (do_clr) begin
                    r_pair[r_tgt][rd_id] <= 1'b0;
                    r_pair[rd_id][r_tgt] <= 1'b0;
                end
            end
            if (i_cmd.clr) begin
                for (int k = 0; k < MAX_BODIES; k++) r_pair[k][r_tgt] <= 1'b0;
                r_pair[r_tgt] <= '0;
            end
            if (i_cmd.rm_rd && !rm_more && r_ax) begin
                r_cnt         <= r_w;
                r_slot[r_tgt] <= 1'b0;
            end
        end
    end

    // request capture and per-command counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.cmd;
            r_id5   <= i_req.body_id;
            r_lo[0] <= i_req.min_x[COORD_BITS-1:0];
            r_lo[1] <= i_req.min_y[COORD_BITS-1:0];
            r_hi[0] <= i_req.max_x[COORD_BITS-1:0];
            r_hi[1] <= i_req.max_y[COORD_BITS-1:0];
        end
        if (i_cmd.decode) begin
            r_tgt    <= tgt_dec;
            r_before <= (r_op == CMD_ADD) ? '0 : r_pair[id_w];
            r_dn_a   <= dn_a;
            r_dn_st  <= dn_st;
            r_is_add <= (r_op == CMD_ADD);
            r_mv     <= '0;
            r_o      <= '0;
            r_r      <= '0;
            r_w      <= '0;
            r_ax     <= 1'b0;
        end
        if (i_cmd.mv_start) r_i <= r_pos[r_tgt][r_mv];
        if (i_cmd.mv_load)  r_left <= left_ld;
        if (i_cmd.mv_cmp && swap) r_i <= j;
        if (i_cmd.mv_end)   r_mv <= r_mv + 2'd1;
        if (i_cmd.rm_rd && !rm_more && !r_ax) begin
            r_ax <= 1'b1;
            r_r  <= '0;
            r_w  <= '0;
        end
        if (i_cmd.rm_wr) begin
            r_r <= r_r + CNW'(1);
            if (keep) r_w <= r_w + CNW'(1);
        end
        if (i_cmd.emit && o_st.emit_adv) r_o <= r_o + IDW'(1);
    end

    // result register
    assign diff     = r_before[r_o] ^ r_pair[r_tgt][r_o];
    assign out_free = !r_ov || o_res.ready;
    assign pair_ld  = i_cmd.emit && diff && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (pair_ld || (i_cmd.done_ld && out_free)) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_ld) begin
            r_okind <= r_pair[r_tgt][r_o] ? KIND_ADD : KIND_DEL;
            r_oa    <= 5'((r_o < r_tgt) ? r_o : r_tgt);
            r_ob    <= 5'((r_o < r_tgt) ? r_tgt : r_o);
            r_ost   <= STAT_OK;
            r_olast <= 1'b0;
        end else if (i_cmd.done_ld && out_free) begin
            r_okind <= KIND_DONE;
            r_oa    <= r_dn_a;
            r_ob    <= 5'd0;
            r_ost   <= r_dn_st;
            r_olast <= 1'b1;
        end
    end

    assign o_res.valid  = r_ov;
    assign o_res.kind   = r_okind;
    assign o_res.body_a = r_oa;
    assign o_res.body_b = r_ob;
    assign o_res.status = r_ost;
    assign o_res.last   = r_olast;

    assign o_st.in_valid  = i_req.valid;
    assign o_st.dec       = dec;
    assign o_st.walk_go   = walk_go;
    assign o_st.mv_last   = (r_mv == 2'd3);
    assign o_st.rm_more   = rm_more;
    assign o_st.rm_axis1  = r_ax;
    assign o_st.emit_adv  = !diff || out_free;
    assign o_st.emit_last = (r_o == LAST_ID);
    assign o_st.out_free  = out_free;

    a_cnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] == 1'b0) && (int'(r_cnt) <= EPN))
        else $error("endpoint count out of range");

    a_cnt_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idle |-> (($countones(r_slot) * 2) == int'(r_cnt)))
        else $error("endpoint count disagrees with slot map");

    a_no_self_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair_ld |-> (r_o != r_tgt))
        else $error("self pair emitted");

    a_walk_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mv_cmp && swap && walk_go) |-> (raddr != waddr))
        else $error("walk reads the entry it writes");

endmodule

@@ hw/rtl/sweep_prune_broadphase_2d.sv @@
// Top level: 2-D sweep-and-prune broad phase, request in, pair changes and done out.
// Sequence: add and update walk each of the four endpoints through the sorted lists, then
//   scan every body for pair changes; remove compacts both endpoint lists, then scans the pairs.
// Throughput: one request at a time; the walk does one endpoint swap per cycle
//   through the registered read of the endpoint list memory.
// Reset: synchronous active-low; clears slot map, endpoint count, pair matrix and result valid at once.
module sweep_prune_broadphase_2d import spb_pkg::*; #(
    parameter int MAX_BODIES = MAX_BODIES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spb_req_if.sink   i_req,
    spb_res_if.source o_res
);

    t_dp_cmd  cmd;
    t_dp_stat st;

    spb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    spb_dp #(
        .MAX_BODIES (MAX_BODIES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_st    (st),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

@@ tb/sv/tb_sweep_prune_broadphase_2d.sv @@
// Testbench for the 2-D sweep-and-prune broad phase: directed and random commands.
`timescale 1ns / 100ps

module tb_sweep_prune_broadphase_2d;
    import spb_pkg::*;

    localparam int NB        = MAX_BODIES_DEF;
    localparam int EP_LIMIT  = 2 * NB;
    localparam int MAX_CYCLES = 3_000_000;
    localparam int UNIT      = 1 << 16;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] body_a;
        logic [4:0] body_b;
        logic [1:0] status;
        logic       last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    spb_req_if req_if ();
    spb_res_if res_if ();

    sweep_prune_broadphase_2d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------- broad-phase predictor ----------------
    longint     ep_val  [2][EP_LIMIT];
    bit         ep_ismin[2][EP_LIMIT];
    int         ep_body [2][EP_LIMIT];
    int         ep_cnt;
    longint     box_lo  [NB][2];
    longint     box_hi  [NB][2];
    int         ep_pos  [NB][4];
    bit [NB-1:0] slot_used;
    bit [NB-1:0] pairs  [NB];

    t_result    pending_results[$];

    int mismatches, n_requests, n_results, n_pair_adds, n_pair_dels, n_full, n_unused;
    int burst_left;
    longint cycle_count;

    function automatic bit boxes_touch(int a, int b);
        for (int k = 0; k < 2; k++) begin
            if (box_lo[a][k] > box_hi[b][k]) return 1'b0;
            if (box_lo[b][k] > box_hi[a][k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void link_pair(int a, int b);
        if (a == b || !boxes_touch(a, b)) return;
        pairs[a][b] = 1'b1;
        pairs[b][a] = 1'b1;
    endfunction

    function automatic void unlink_pair(int a, int b);
        if (a == b) return;
        pairs[a][b] = 1'b0;
        pairs[b][a] = 1'b0;
    endfunction

    function automatic void note_pos(int ax, int idx);
        ep_pos[ep_body[ax][idx]][ax * 2 + (ep_ismin[ax][idx] ? 0 : 1)] = idx;
    endfunction

    // insertion-sort walk of one endpoint; the moving entry keeps its old value
    function automatic void slide_endpoint(int ax, int idx, longint nv, bit leftward);
        int     i, j;
        longint mv, ov;
        bit     mm, om;
        int     mb, ob;
        if (idx >= ep_cnt) return;
        i = idx;
        mv = ep_val[ax][idx]; mm = ep_ismin[ax][idx]; mb = ep_body[ax][idx];
        forever begin
            if (leftward) begin
                if (i == 0) break;
                j = i - 1;
                if (!(ep_val[ax][j] > nv)) break;
            end else begin
                if (i + 1 >= ep_cnt) break;
                j = i + 1;
                if (!(ep_val[ax][j] < nv)) break;
            end
            ov = ep_val[ax][j]; om = ep_ismin[ax][j]; ob = ep_body[ax][j];
            if (leftward) begin
                if (mm && !om) link_pair(mb, ob);
                if (!mm && om) unlink_pair(mb, ob);
            end else begin
                if (!mm && om) link_pair(mb, ob);
                if (mm && !om) unlink_pair(mb, ob);
            end
            ep_val[ax][j] = mv; ep_ismin[ax][j] = mm; ep_body[ax][j] = mb;
            ep_val[ax][i] = ov; ep_ismin[ax][i] = om; ep_body[ax][i] = ob;
            note_pos(ax, j);
            note_pos(ax, i);
            i = j;
        end
    endfunction

    function automatic void push_result(logic [1:0] kind, int a, int b, logic [1:0] st,
                                        logic lst);
        t_result r;
        r.kind = kind; r.body_a = a[4:0]; r.body_b = b[4:0]; r.status = st; r.last = lst;
        pending_results = {pending_results, r};
    endfunction

    function automatic void push_pair_changes(int body, bit [NB-1:0] prior);
        for (int o = 0; o < NB; o++)
            if (prior[o] != pairs[body][o])
                push_result(pairs[body][o] ? KIND_ADD : KIND_DEL,
                            (o < body) ? o : body, (o < body) ? body : o, STAT_OK, 1'b0);
    endfunction

    function automatic void predict_request(logic [1:0] cmd, logic [4:0] id,
                                            logic signed [31:0] mnx, logic signed [31:0] mny,
                                            logic signed [31:0] mxx, logic signed [31:0] mxy);
        longint lo[2], hi[2];
        int s, w, p;
        bit [NB-1:0] prior;
        longint nv;
        lo[0] = mnx; lo[1] = mny; hi[0] = mxx; hi[1] = mxy;
        if (cmd == CMD_ADD) begin
            s = NB;
            for (int k = NB - 1; k >= 0; k--) if (!slot_used[k]) s = k;
            if (s >= NB || ep_cnt + 2 > EP_LIMIT) begin
                push_result(KIND_DONE, 0, 0, STAT_FULL, 1'b1);
                n_full++;
                return;
            end
            slot_used[s] = 1'b1;
            pairs[s] = '0;
            for (int ax = 0; ax < 2; ax++) begin
                box_lo[s][ax] = lo[ax]; box_hi[s][ax] = hi[ax];
                ep_val[ax][ep_cnt] = lo[ax]; ep_ismin[ax][ep_cnt] = 1; ep_body[ax][ep_cnt] = s;
                ep_val[ax][ep_cnt + 1] = hi[ax]; ep_ismin[ax][ep_cnt + 1] = 0;
                ep_body[ax][ep_cnt + 1] = s;
                ep_pos[s][ax * 2] = ep_cnt;
                ep_pos[s][ax * 2 + 1] = ep_cnt + 1;
            end
            ep_cnt += 2;
            for (int ax = 0; ax < 2; ax++) begin
                slide_endpoint(ax, ep_pos[s][ax * 2], lo[ax], 1'b1);
                slide_endpoint(ax, ep_pos[s][ax * 2 + 1], hi[ax], 1'b1);
            end
            push_pair_changes(s, '0);
            push_result(KIND_DONE, s, 0, STAT_OK, 1'b1);
            return;
        end
        if (cmd == CMD_NONE) begin
            push_result(KIND_DONE, 0, 0, STAT_OK, 1'b1);
            return;
        end
        if (!slot_used[id]) begin
            push_result(KIND_DONE, id, 0, STAT_UNUSED, 1'b1);
            n_unused++;
            return;
        end
        prior = pairs[id];
        if (cmd == CMD_REMOVE) begin
            for (int o = 0; o < NB; o++) unlink_pair(id, o);
            for (int ax = 0; ax < 2; ax++) begin
                w = 0;
                for (int r = 0; r < ep_cnt; r++) begin
                    if (ep_body[ax][r] == id) continue;
                    ep_val[ax][w] = ep_val[ax][r];
                    ep_ismin[ax][w] = ep_ismin[ax][r];
                    ep_body[ax][w] = ep_body[ax][r];
                    note_pos(ax, w);
                    w++;
                end
            end
            ep_cnt = w;
            slot_used[id] = 1'b0;
            pairs[id] = '0;
        end else begin
            for (int ax = 0; ax < 2; ax++) begin
                box_lo[id][ax] = lo[ax]; box_hi[id][ax] = hi[ax];
            end
            for (int ax = 0; ax < 2; ax++)
                for (int k = 0; k < 2; k++) begin
                    p = ep_pos[id][ax * 2 + k];
                    nv = k ? hi[ax] : lo[ax];
                    if (p >= ep_cnt) continue;
                    slide_endpoint(ax, p, nv, nv < ep_val[ax][p]);
                    p = ep_pos[id][ax * 2 + k];
                    if (p < ep_cnt) ep_val[ax][p] = nv;
                end
        end
        push_pair_changes(id, prior);
        push_result(KIND_DONE, id, 0, STAT_OK, 1'b1);
    endfunction

    // ---------------- request driver ----------------
    task automatic send_request(logic [1:0] cmd, logic [4:0] id,
                                logic signed [31:0] mnx, logic signed [31:0] mny,
                                logic signed [31:0] mxx, logic signed [31:0] mxy);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= cmd;
        req_if.body_id <= id;
        req_if.min_x   <= mnx;
        req_if.min_y   <= mny;
        req_if.max_x   <= mxx;
        req_if.max_y   <= mxy;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(cmd, id, mnx, mny, mxx, mxy);
        n_requests++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // ---------------- result receiver and checker ----------------
    int rx_mode, rx_mode_left;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_mode      <= 0;
            rx_mode_left <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 9) < 7);
                2: res_if.ready <= (cycle_count % 4 == 0);
                default: res_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind = res_if.kind; got.body_a = res_if.body_a; got.body_b = res_if.body_b;
            got.status = res_if.status; got.last = res_if.last;
            n_results++;
            if (got.kind == KIND_ADD) n_pair_adds++;
            if (got.kind == KIND_DEL) n_pair_dels++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result kind=%0d a=%0d b=%0d st=%0d last=%0d",
                             $realtime, got.kind, got.body_a, got.body_b, got.status,
                             got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.body_a !== want.body_a ||
                    got.body_b !== want.body_b || got.status !== want.status ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: exp kind=%0d a=%0d b=%0d st=%0d last=%0d,",
                                 $realtime, want.kind, want.body_a, want.body_b,
                                 want.status, want.last,
                                 " got kind=%0d a=%0d b=%0d st=%0d last=%0d",
                                 got.kind, got.body_a, got.body_b, got.status, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 40 * UNIT)) - 20 * UNIT;
    endfunction

    function automatic int bodies_in_use();
        return $countones(slot_used);
    endfunction

    function automatic logic [4:0] pick_used_body();
        int k;
        do k = $urandom_range(0, NB - 1); while (!slot_used[k]);
        return k[4:0];
    endfunction

    task automatic send_random_box(logic [1:0] cmd, logic [4:0] id);
        logic signed [31:0] mnx, mny, sx, sy;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_request(cmd, id, $urandom, $urandom, $urandom, $urandom);
        end else begin
            if (cmd == CMD_UPDATE && r < 70) begin
                // coherent motion: small jitter of the current box
                mnx = 32'(box_lo[id][0] + $signed($urandom_range(0, 2 * UNIT)) - UNIT);
                mny = 32'(box_lo[id][1] + $signed($urandom_range(0, 2 * UNIT)) - UNIT);
                sx  = 32'(box_hi[id][0] - box_lo[id][0] + $signed($urandom_range(0, UNIT / 2))
                      - UNIT / 4);
                sy  = 32'(box_hi[id][1] - box_lo[id][1] + $signed($urandom_range(0, UNIT / 2))
                      - UNIT / 4);
            end else begin
                mnx = near_coord(); mny = near_coord();
                sx = $urandom_range(0, 8 * UNIT); sy = $urandom_range(0, 8 * UNIT);
            end
            if (r >= 95) sx = -sx - 1;     // inverted box
            send_request(cmd, id, mnx, mny, mnx + sx, mny + sy);
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed_basics();
        send_request(CMD_ADD, 5'd0, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7fff_ffff, 32'sh7fff_ffff);
        send_request(CMD_ADD, 5'd31, 0, 0, UNIT, UNIT);
        send_request(CMD_ADD, 5'd0, 0, 0, UNIT, UNIT);                 // exact tie
        send_request(CMD_ADD, 5'd0, UNIT, UNIT, 2 * UNIT, 2 * UNIT);   // touching corner
        send_request(CMD_UPDATE, 5'd1, 10 * UNIT, 10 * UNIT, 11 * UNIT, 11 * UNIT);
        send_request(CMD_UPDATE, 5'd1, -UNIT, -UNIT, 3 * UNIT, 3 * UNIT);
        send_request(CMD_UPDATE, 5'd3, -5 * UNIT, -5 * UNIT, -6 * UNIT, -6 * UNIT);
        send_request(CMD_UPDATE, 5'd3, 0, 0, UNIT / 2, UNIT / 2);
        send_request(CMD_REMOVE, 5'd2, 0, 0, 0, 0);
        send_request(CMD_REMOVE, 5'd2, 0, 0, 0, 0);                    // now unused
        send_request(CMD_UPDATE, 5'd31, 0, 0, 0, 0);                   // never used
        send_request(CMD_NONE, 5'd31, 32'shffff_ffff, 0, 0, 32'shffff_ffff);
        send_request(CMD_ADD, 5'd0, 32'sh7fff_ffff, 32'sh7fff_ffff,
                     32'sh8000_0000, 32'sh8000_0000);                  // inverted extremes
        send_request(CMD_UPDATE, 5'd0, 32'sh7fff_ffff, 32'sh8000_0000,
                     32'sh7fff_ffff, 32'sh7fff_ffff);
        send_request(CMD_REMOVE, 5'd0, 0, 0, 0, 0);
        send_request(CMD_REMOVE, 5'd1, 0, 0, 0, 0);
    endtask

    task automatic test_full_table();
        while (bodies_in_use() < NB) send_random_box(CMD_ADD, 5'd0);
        send_request(CMD_ADD, 5'd0, 0, 0, UNIT, UNIT);
        send_request(CMD_REMOVE, 5'd17, 0, 0, 0, 0);
        send_request(CMD_ADD, 5'd0, 0, 0, UNIT, UNIT);                 // reuses the gap
        while (bodies_in_use() > 0) send_request(CMD_REMOVE, pick_used_body(), 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (bodies_in_use() < 4 || r < 30) send_random_box(CMD_ADD, 5'($urandom));
            else if (r < 42) send_request(CMD_REMOVE, pick_used_body(), $urandom, $urandom,
                                          $urandom, $urandom);
            else if (r < 92) send_random_box(CMD_UPDATE, pick_used_body());
            else if (r < 97) send_random_box(2'($urandom_range(1, 2)), 5'($urandom));
            else send_request(CMD_NONE, 5'($urandom), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0; req_if.cmd = CMD_NONE; req_if.body_id = '0;
        req_if.min_x = '0; req_if.min_y = '0; req_if.max_x = '0; req_if.max_y = '0;
        res_if.ready = 1'b0;
        cycle_count = 0;
        mismatches = 0; n_requests = 0; n_results = 0; n_pair_adds = 0; n_pair_dels = 0;
        n_full = 0; n_unused = 0; burst_left = 0;
        ep_cnt = 0; slot_used = '0;
        foreach (pairs[k]) pairs[k] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_basics();
        test_full_table();
        test_random_traffic(390);
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Covered %0d requests (%0d table-full, %0d unused body), %0d results checked",
                 n_requests, n_full, n_unused, n_results);
        $display("Pair events seen: %0d added, %0d removed; mismatches %0d",
                 n_pair_adds, n_pair_dels, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
